// ----- sv/catmull_rom_curve_eval_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the curve evaluator
// Shared property wrappers.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_CURVE_EVAL_CORE_DEFINES_SVH
`define CATMULL_ROM_CURVE_EVAL_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/crc_eval_pkg.sv -----
// ----------------------------------------------------------------------------
// crc_eval_pkg
// Types and constants shared by the curve evaluator modules.
// ----------------------------------------------------------------------------
package crc_eval_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_BELOW  = 2'd1,
        REGION_ABOVE  = 2'd2
    } region_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // front to back job word
    typedef struct packed {
        logic                  clamped;
        region_t               region;
        logic signed [31:0]    clamp_y;
        logic signed [31:0]    y0;
        logic signed [31:0]    y1;
        logic signed [31:0]    y2;
        logic signed [31:0]    y3;
        logic        [32:0]    num;
        logic        [32:0]    den;
    } job_t;

endpackage

// ----- sv/crc_eval_front.sv -----
// ----------------------------------------------------------------------------
// crc_eval_front
// Point table, range classification and interval search, one query at a time.
// ----------------------------------------------------------------------------
module crc_eval_front #(
    parameter int MAX_POINTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [4:0]               point_count,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [3:0]               point_index,
    input  logic signed [31:0]       point_x,
    input  logic signed [31:0]       point_y,
    input  logic signed [31:0]       query_t,
    output logic                     job_valid,
    input  logic                     job_ready,
    output crc_eval_pkg::job_t       job
);
    import crc_eval_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [1:0] { S_IDLE, S_SEARCH, S_FETCH, S_SEND } state_t;

    logic signed [31:0] xtab [MAX_POINTS];
    logic signed [31:0] ytab [MAX_POINTS];

    state_t              state_reg;
    logic signed [31:0]  t_reg;
    logic [IW-1:0]       n1_reg;    // last index in use
    logic [CW-1:0]       ip_reg;
    logic [IW-1:0]       i_reg;
    job_t                job_reg;

    logic [CW-1:0] n_eff;
    logic [IW-1:0] i0, i3, im1;
    logic load_ok;

    always_comb
    begin
        if (point_count < 5'd2)
            n_eff = CW'(2);
        else if (32'(point_count) > MAX_POINTS)
            n_eff = CW'(MAX_POINTS);
        else
            n_eff = CW'(point_count);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_SEND);
    assign job       = job_reg;
    assign load_ok   = (32'(point_index) < MAX_POINTS);
    assign im1 = i_reg - IW'(1);
    assign i0  = (i_reg > IW'(1)) ? i_reg - IW'(2) : '0;
    assign i3  = (i_reg < n1_reg) ? i_reg + IW'(1) : n1_reg;

    // table write
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && kind == KIND_LOAD && load_ok)
        begin
            xtab[point_index[IW-1:0]] <= point_x;
            ytab[point_index[IW-1:0]] <= point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && kind == KIND_QUERY)
                    begin
                        t_reg  <= query_t;
                        n1_reg <= IW'(n_eff - CW'(1));
                        ip_reg <= CW'(1);
                        if (query_t < xtab[0])
                        begin
                            job_reg.clamped <= 1'b1;
                            job_reg.region  <= REGION_BELOW;
                            job_reg.clamp_y <= ytab[0];
                            state_reg       <= S_SEND;
                        end
                        else if (query_t >= xtab[IW'(n_eff - CW'(1))])
                        begin
                            job_reg.clamped <= 1'b1;
                            job_reg.region  <= REGION_ABOVE;
                            job_reg.clamp_y <= ytab[IW'(n_eff - CW'(1))];
                            state_reg       <= S_SEND;
                        end
                        else
                        begin
                            job_reg.clamped <= 1'b0;
                            job_reg.region  <= REGION_INSIDE;
                            state_reg       <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // one comparison a cycle; last in-use point always exceeds t
                    i_reg <= IW'(ip_reg);
                    if (xtab[IW'(ip_reg)] > t_reg || IW'(ip_reg) == n1_reg)
                        state_reg <= S_FETCH;
                    else
                        ip_reg <= ip_reg + CW'(1);
                end
                S_FETCH:
                begin
                    job_reg.y0  <= ytab[i0];
                    job_reg.y1  <= ytab[im1];
                    job_reg.y2  <= ytab[i_reg];
                    job_reg.y3  <= ytab[i3];
                    job_reg.num <= 33'(t_reg) - 33'(xtab[im1]);
                    job_reg.den <= (xtab[i_reg] == xtab[im1]) ? 33'd1
                                 : 33'(xtab[i_reg]) - 33'(xtab[im1]);
                    state_reg   <= S_SEND;
                end
                S_SEND:
                begin
                    if (job_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "catmull_rom_curve_eval_core_defines.svh"
    `CR_ASSERT_NXT(a_send_holds, clk, rst_n, job_valid && !job_ready, job_valid, "job dropped")
    `CR_ASSERT_IMP(a_busy_blocks, clk, rst_n, state_reg != S_IDLE, !in_ready, "accept while busy")
    `CR_ASSERT_NXT(a_search_bound, clk, rst_n, state_reg == S_SEARCH, ip_reg <= CW'(MAX_POINTS),
                   "search overran")
endmodule

// ----- sv/crc_eval_fifo.sv -----
// ----------------------------------------------------------------------------
// crc_eval_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module crc_eval_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  crc_eval_pkg::job_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output crc_eval_pkg::job_t  rd_data
);
    import crc_eval_pkg::*;

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= ~wp_reg;
            if (do_rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end
endmodule

// ----- sv/crc_eval_back.sv -----
// ----------------------------------------------------------------------------
// crc_eval_back
// Radix-2 divider for the local parameter, Horner evaluation on one multiplier,
// and an output register.
// ----------------------------------------------------------------------------
module crc_eval_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  crc_eval_pkg::job_t       job,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [31:0]       curve_value,
    output logic [1:0]               region
);
    import crc_eval_pkg::*;

    localparam int QW = 33 + FRAC_BITS;   // dividend width
    localparam int CW = $clog2(QW + 1);
    localparam int HW = 40;               // coefficient width, covers |d|,|c| <= 12*2^31
    localparam int PW = HW + FRAC_BITS + 1;

    typedef enum logic [2:0] { S_IDLE, S_DIV, S_COEF, S_MUL, S_ADD, S_OUT } state_t;

    state_t                state_reg;
    logic [QW-1:0]         q_reg;        // dividend shifting into quotient
    logic [33:0]           r_reg;
    logic [32:0]           den_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [HW-1:0]  h_reg, a_reg, b_reg, c_reg;
    logic signed [PW-1:0]  p_reg;
    logic [1:0]            step_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    out_val_reg;
    region_t               out_reg_reg;
    logic signed [31:0]    y0_reg, y1_reg, y2_reg, y3_reg;

    logic [33:0]           r_sh;
    logic signed [HW-1:0]  sy0, sy1, sy2, sy3, h_sum;
    logic signed [HW-1:0]  c_add;
    logic signed [HW-1:0]  h_half;

    assign r_sh = {r_reg[32:0], q_reg[QW-1]};
    assign sy0 = HW'(y0_reg);
    assign sy1 = HW'(y1_reg);
    assign sy2 = HW'(y2_reg);
    assign sy3 = HW'(y3_reg);

    always_comb
    begin
        unique case (step_reg)
            2'd0:    c_add = c_reg;
            2'd1:    c_add = b_reg;
            default: c_add = a_reg;
        endcase
    end

    // arithmetic shift is floor division by 2^FRAC_BITS
    assign h_sum  = c_add + HW'(p_reg >>> FRAC_BITS);
    assign h_half = h_reg >>> 1;

    assign job_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign empty       = !out_valid_reg;
    assign curve_value = out_val_reg;
    assign region      = out_reg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        out_reg_reg <= job.region;
                        if (job.clamped)
                        begin
                            out_val_reg   <= job.clamp_y;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            q_reg     <= {job.num, FRAC_BITS'(0)};
                            r_reg     <= '0;
                            den_reg   <= job.den;
                            cnt_reg   <= CW'(QW);
                            y0_reg    <= job.y0;
                            y1_reg    <= job.y1;
                            y2_reg    <= job.y2;
                            y3_reg    <= job.y3;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (r_sh >= {1'b0, den_reg})
                    begin
                        r_reg <= r_sh - {1'b0, den_reg};
                        q_reg <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_sh;
                        q_reg <= {q_reg[QW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_COEF;
                end
                S_COEF:
                begin
                    a_reg <= sy1 <<< 1;
                    b_reg <= sy2 - sy0;
                    c_reg <= (sy0 <<< 1) - (sy1 <<< 2) - sy1 + (sy2 <<< 2) - sy3;
                    h_reg <= sy3 - sy0 + (sy1 <<< 1) + sy1 - (sy2 <<< 1) - sy2;
                    step_reg  <= 2'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // u below 2^FRAC_BITS
                    p_reg     <= PW'(h_reg) * PW'($signed({1'b0, q_reg[FRAC_BITS-1:0]}));
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    h_reg <= h_sum;
                    if (step_reg == 2'd2)
                        state_reg <= S_OUT;
                    else
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (h_half > HW'(32'sh7fffffff))
                        out_val_reg <= 32'sh7fffffff;
                    else if (h_half < -HW'(33'sh080000000))
                        out_val_reg <= 32'sh80000000;
                    else
                        out_val_reg <= 32'(h_half);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "catmull_rom_curve_eval_core_defines.svh"
    `CR_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid_reg && !pop, out_valid_reg && $stable(out_val_reg),
                   "result changed before pop")
    `CR_ASSERT_IMP(a_no_take_full, clk, rst_n, out_valid_reg, !job_ready, "job taken over result")
    `CR_ASSERT_IMP(a_den_nonzero, clk, rst_n, state_reg == S_DIV, den_reg != 33'd0, "zero divisor")
endmodule

// ----- sv/catmull_rom_curve_eval_core.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_curve_eval_core
// Catmull-Rom evaluator over a loaded table of Q16.16 control points.
// ----------------------------------------------------------------------------
//  channel   | handshake          | words
//  ----------+--------------------+-----------------------------------------
//  input     | push / full        | kind, point_index, point_x, point_y, query_t
//  result    | pop / empty        | curve_value, region
//  config    | cfg_we / cfg_data  | point_count
//
//  A load word is written to the point table as it is accepted and leaves the front
//  idle. A clamped query passes from the front's job register through the job queue
//  to the back's output register. An inside query is searched and fetched in the
//  front, then divided and evaluated by Horner's rule on one multiplier in the back.
//  Front and back are joined by a 2-entry job queue, so the front searches the next
//  query while the back divides. A full result register stalls the back; full is high
//  whenever the front is busy with a query, until its job is taken by the queue.
//  Reset clears control state and sets point_count to 2; the point table has no reset.
// ----------------------------------------------------------------------------
module catmull_rom_curve_eval_core #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data,
    input  logic                push,
    output logic                full,
    input  logic                kind,
    input  logic [3:0]          point_index,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  query_t,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  curve_value,
    output logic [1:0]          region
);
    import crc_eval_pkg::*;

    logic [4:0] point_count_reg;
    logic       in_ready;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    job_t       fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= 5'd2;
        else if (cfg_we)
            point_count_reg <= cfg_data;
    end

    assign full = !in_ready;

    crc_eval_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk, .rst_n,
        .point_count (point_count_reg),
        .in_valid    (push),
        .in_ready    (in_ready),
        .kind, .point_index, .point_x, .point_y, .query_t,
        .job_valid   (fj_valid),
        .job_ready   (fj_ready),
        .job         (fj)
    );

    crc_eval_fifo u_fifo (
        .clk, .rst_n,
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj)
    );

    crc_eval_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n,
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .empty, .pop, .curve_value, .region
    );
endmodule
